@@ hdl/rcbc_pkg.sv @@
// Shared types and constants of the raster cell boundary classifier.
`default_nettype none

package rcbc_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int BYTE_W     = 8;
	localparam int RLEN_W     = 9;
	localparam int HEIGHT_W   = 11;
	localparam int COLUMN_W   = 8;
	localparam int ROWS_W     = 2;

	localparam logic [CFG_IDX_W-1:0] REG_TOKEN_CHAR  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_ROWS = 2'd2;

	localparam logic [BYTE_W-1:0]   TOKEN_CHAR_RST  = 8'd35;
	localparam logic [RLEN_W-1:0]   ROW_LENGTH_RST  = 9'd256;
	localparam logic [HEIGHT_W-1:0] ACTIVE_ROWS_RST = 11'd1024;

	localparam logic [ROWS_W-1:0] ROWS_NONE  = 2'd0;
	localparam logic [ROWS_W-1:0] ROWS_FIRST = 2'd1;
	localparam logic [ROWS_W-1:0] ROWS_LATER = 2'd2;

	typedef enum logic [1:0] {
		SEQ_RUN,
		SEQ_UNWIND,
		SEQ_WIND
	} rcbc_seq_state_t;

	typedef struct packed {
		logic run;
		logic rotate;
	} rcbc_seq_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} rcbc_cell_ctrl_t;

	typedef struct packed {
		logic [COLUMN_W-1:0] column;
		logic [HEIGHT_W-1:0] height;
		logic                left_open;
		logic                right_open;
		logic                top_open;
		logic                bottom_open;
		logic                internal;
		logic                last_row;
	} rcbc_result_t;

endpackage

`default_nettype wire

@@ hdl/rcbc_cell.sv @@
// One column cell of the rotating line-store ring: upper and centre token marks.
`default_nettype none

module rcbc_cell (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire rcbc_pkg::rcbc_cell_ctrl_t ctrl,
	input  wire logic                     active,
	input  wire logic                     tail,
	input  wire logic                     nbr_upper,
	input  wire logic                     nbr_centre,
	input  wire logic                     feed_upper,
	input  wire logic                     feed_centre,
	output logic                          upper_q,
	output logic                          centre_q
);
	import rcbc_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q  <= 1'b0;
			centre_q <= 1'b0;
		end else if (ctrl.clear) begin
			upper_q  <= 1'b0;
			centre_q <= 1'b0;
		end else if (ctrl.shift && active) begin
			if (tail) begin
				upper_q  <= feed_upper;
				centre_q <= feed_centre;
			end else begin
				upper_q  <= nbr_upper;
				centre_q <= nbr_centre;
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/rcbc_align.sv @@
// Ring length and phase tracking, with realignment after a row length change.
`default_nettype none

module rcbc_align #(
	parameter  int MAX_WIDTH = 256,
	localparam int LEN_W     = $clog2(MAX_WIDTH + 1),
	localparam int COL_W     = $clog2(MAX_WIDTH)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [LEN_W-1:0]   eff_len,
	input  wire logic [COL_W-1:0]   col,
	input  wire logic               item_shift,
	output rcbc_pkg::rcbc_seq_t     seq,
	output logic [LEN_W-1:0]        ring_len,
	output logic [COL_W-1:0]        phase
);
	import rcbc_pkg::*;

	localparam int RESET_LEN = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;

	rcbc_seq_state_t  state_q, state_next;
	logic [LEN_W-1:0] ring_len_q;
	logic [COL_W-1:0] ph_q;
	logic [COL_W-1:0] target;
	logic [COL_W-1:0] ph_next;
	logic             ph_wrap;
	logic             len_match;

	assign len_match = (eff_len == ring_len_q);
	assign target    = (LEN_W'(col) >= eff_len) ? '0 : col;
	assign ph_wrap   = ((LEN_W'(ph_q) + LEN_W'(1)) == ring_len_q);
	assign ph_next   = ph_wrap ? '0 : ph_q + COL_W'(1);

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			SEQ_RUN: begin
				if (!len_match) state_next = SEQ_UNWIND;
			end
			SEQ_UNWIND: begin
				if (ph_q == '0) state_next = SEQ_WIND;
			end
			SEQ_WIND: begin
				if (!len_match) state_next = SEQ_UNWIND;
				else if (ph_q == target) state_next = SEQ_RUN;
			end
			default: state_next = SEQ_RUN;
		endcase
	end

	always_comb begin
		seq = '0;
		unique case (state_q)
			SEQ_RUN: begin
				seq.run = len_match;
			end
			SEQ_UNWIND: begin
				seq.rotate = (ph_q != '0);
			end
			SEQ_WIND: begin
				seq.rotate = len_match && (ph_q != target);
			end
			default: seq = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= SEQ_RUN;
			ring_len_q <= LEN_W'(RESET_LEN);
			ph_q       <= '0;
		end else begin
			state_q <= state_next;
			if (state_q == SEQ_UNWIND && ph_q == '0) ring_len_q <= eff_len;
			if (seq.rotate || item_shift) ph_q <= ph_next;
		end
	end

	assign ring_len = ring_len_q;
	assign phase    = ph_q;

endmodule

`default_nettype wire

@@ hdl/raster_cell_boundary_classifier_top.sv @@
// Raster cell boundary classifier: token cells of a streamed raster, four-side exposure.
// Throughput: one item per cycle while the ring is aligned and the skid entry is empty; each result is registered.
// A two-entry output stage (register plus skid) keeps input flowing while a result waits.
// After a row length change the column-cell ring realigns, with input held.
// Reset clears both line stores, all counters and empties the output stage; registers take their defaults.
`default_nettype none

module raster_cell_boundary_classifier_top #(
	parameter int MAX_WIDTH = 256,
	parameter int MAX_ROWS  = 1024
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [rcbc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [rcbc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [rcbc_pkg::BYTE_W-1:0]      cell_byte,
	input  wire logic                             pad_row,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [rcbc_pkg::COLUMN_W-1:0]         column,
	output logic [rcbc_pkg::HEIGHT_W-1:0]         height,
	output logic                                  left_open,
	output logic                                  right_open,
	output logic                                  top_open,
	output logic                                  bottom_open,
	output logic                                  internal,
	output logic                                  last_row
);
	import rcbc_pkg::*;

	localparam int LEN_W     = $clog2(MAX_WIDTH + 1);
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int IDX_LIMIT = ((MAX_ROWS - 1) > 2047) ? 2047 : (MAX_ROWS - 1);
	localparam int RI_W      = $clog2(IDX_LIMIT + 1);
	localparam int CMP_W     = (LEN_W > RLEN_W) ? LEN_W : RLEN_W;

	logic [BYTE_W-1:0]   token_char_q;
	logic [RLEN_W-1:0]   row_length_q;
	logic [HEIGHT_W-1:0] active_rows_q;

	logic [COL_W-1:0]  col_q;
	logic [RI_W-1:0]   row_index_q;
	logic [ROWS_W-1:0] rows_seen_q;
	logic              tail_upper_q;

	logic [CMP_W-1:0]  rl_ext;
	logic [LEN_W-1:0]  eff_len;
	logic [LEN_W-1:0]  ring_len;
	logic [COL_W-1:0]  phase;
	rcbc_seq_t         seq;
	rcbc_cell_ctrl_t   cell_ctrl;

	logic [MAX_WIDTH-1:0] up_bits;
	logic [MAX_WIDTH-1:0] ce_bits;
	logic                 feed_upper;
	logic                 feed_centre;

	logic         fire;
	logic         tok;
	logic         last_col;
	logic         res_hit;
	rcbc_result_t res;
	rcbc_result_t out_q;
	rcbc_result_t skid_q;
	logic         out_v_q;
	logic         skid_v_q;
	logic         out_take;
	logic [HEIGHT_W-1:0] ri_ext;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_char_q  <= TOKEN_CHAR_RST;
			row_length_q  <= ROW_LENGTH_RST;
			active_rows_q <= ACTIVE_ROWS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TOKEN_CHAR:  token_char_q  <= cfg_data[BYTE_W-1:0];
				REG_ROW_LENGTH:  row_length_q  <= cfg_data[RLEN_W-1:0];
				REG_ACTIVE_ROWS: active_rows_q <= cfg_data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	assign rl_ext = CMP_W'(row_length_q);

	always_comb begin
		if (rl_ext == '0) eff_len = LEN_W'(1);
		else if (rl_ext > CMP_W'(MAX_WIDTH)) eff_len = LEN_W'(MAX_WIDTH);
		else eff_len = LEN_W'(rl_ext);
	end

	rcbc_align #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_align (
		.clk       (clk),
		.arst_n    (arst_n),
		.eff_len   (eff_len),
		.col       (col_q),
		.item_shift(fire),
		.seq       (seq),
		.ring_len  (ring_len),
		.phase     (phase)
	);

	assign in_ready = seq.run && !skid_v_q;
	assign fire     = in_valid && in_ready;
	assign tok      = !pad_row && (cell_byte == token_char_q);
	assign last_col = ((LEN_W'(phase) + LEN_W'(1)) == ring_len);

	assign feed_upper  = fire ? ce_bits[0] : up_bits[0];
	assign feed_centre = fire ? tok : ce_bits[0];

	assign cell_ctrl.shift = fire || seq.rotate;
	assign cell_ctrl.clear = fire && last_col && pad_row;

	for (genvar p = 0; p < MAX_WIDTH; p++) begin : g_cell
		logic nbr_up;
		logic nbr_ce;
		if (p < MAX_WIDTH - 1) begin : g_mid
			assign nbr_up = up_bits[p+1];
			assign nbr_ce = ce_bits[p+1];
		end else begin : g_end
			assign nbr_up = 1'b0;
			assign nbr_ce = 1'b0;
		end
		rcbc_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cell_ctrl),
			.active     (LEN_W'(p) < ring_len),
			.tail       (LEN_W'(p + 1) == ring_len),
			.nbr_upper  (nbr_up),
			.nbr_centre (nbr_ce),
			.feed_upper (feed_upper),
			.feed_centre(feed_centre),
			.upper_q    (up_bits[p]),
			.centre_q   (ce_bits[p])
		);
	end

	// classify the cell at the head of the ring
	assign ri_ext  = HEIGHT_W'(row_index_q);
	assign res_hit = fire && (rows_seen_q != ROWS_NONE) && ce_bits[0];

	always_comb begin
		res.column      = COLUMN_W'(phase);
		res.height      = (active_rows_q > ri_ext) ? active_rows_q - ri_ext : '0;
		res.left_open   = (phase != '0) && !tail_upper_q;
		res.right_open  = !last_col && !ce_bits[1];
		res.top_open    = (rows_seen_q == ROWS_LATER) && !up_bits[0];
		res.bottom_open = !pad_row && !tok;
		res.internal    = !(res.left_open || res.right_open || res.top_open
			|| res.bottom_open);
		res.last_row    = pad_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_index_q  <= '0;
			rows_seen_q  <= ROWS_NONE;
			tail_upper_q <= 1'b0;
		end else begin
			if (cell_ctrl.shift) tail_upper_q <= feed_upper;
			if (fire) begin
				if (last_col) begin
					col_q <= '0;
					if (pad_row) begin
						row_index_q <= '0;
						rows_seen_q <= ROWS_NONE;
					end else begin
						if (rows_seen_q != ROWS_NONE && row_index_q < RI_W'(IDX_LIMIT))
							row_index_q <= row_index_q + RI_W'(1);
						if (rows_seen_q != ROWS_LATER) rows_seen_q <= rows_seen_q + ROWS_W'(1);
					end
				end else begin
					col_q <= phase + COL_W'(1);
				end
			end
		end
	end

	// output register with skid entry
	assign out_take = out_v_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_take) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (res_hit) begin
			if (!out_v_q || out_take) out_v_q <= 1'b1;
			else skid_v_q <= 1'b1;
		end else if (out_take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_take) out_q <= skid_q;
		end else if (res_hit) begin
			if (!out_v_q || out_take) out_q <= res;
			else skid_q <= res;
		end
	end

	assign out_valid   = out_v_q;
	assign column      = out_q.column;
	assign height      = out_q.height;
	assign left_open   = out_q.left_open;
	assign right_open  = out_q.right_open;
	assign top_open    = out_q.top_open;
	assign bottom_open = out_q.bottom_open;
	assign internal    = out_q.internal;
	assign last_row    = out_q.last_row;

endmodule

`default_nettype wire

@@ hdl/rcbc_checker.sv @@
// Port-level checks of the raster cell boundary classifier, bound to the top level.
`default_nettype none

module rcbc_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            out_valid,
	input wire logic                            out_ready,
	input wire logic [rcbc_pkg::COLUMN_W-1:0]   column,
	input wire logic [rcbc_pkg::HEIGHT_W-1:0]   height,
	input wire logic                            left_open,
	input wire logic                            right_open,
	input wire logic                            top_open,
	input wire logic                            bottom_open,
	input wire logic                            internal,
	input wire logic                            last_row
);
	import rcbc_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(column) && $stable(height) && $stable(last_row))
		else $error("stalled result changed");

	a_internal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> internal == !(left_open || right_open || top_open || bottom_open))
		else $error("internal flag disagrees with side flags");

	a_last_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_row |-> !bottom_open)
		else $error("bottom exposed on final row");

	a_left_border: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && column == '0 |-> !left_open)
		else $error("left border counted as exposed");

endmodule

bind raster_cell_boundary_classifier_top rcbc_checker u_rcbc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.column     (column),
	.height     (height),
	.left_open  (left_open),
	.right_open (right_open),
	.top_open   (top_open),
	.bottom_open(bottom_open),
	.internal   (internal),
	.last_row   (last_row)
);

`default_nettype wire
